/* hw/rtl/hqr_pkg.sv */
// Shared types, codes and constants of the Householder QR factor block.
package hqr_pkg;

	localparam int WORD_W   = 32;
	localparam int FRAC     = 16;
	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int DIM_W    = 5;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int MAX_ROWS = 1 << ROW_W;
	localparam int MAX_COLS = 1 << COL_W;
	localparam int MAG_W    = WORD_W + FRAC;

	localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_FACTOR = 2'd1,
		KIND_READ   = 2'd2,
		KIND_TAU    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {WD_VALUE, WD_PROD, WD_BETA, WD_SUB} wd_sel_t;
	typedef enum logic [2:0] {MA_RD, MA_ALPHA, MA_X, MA_SUM, MA_W} mul_a_t;
	typedef enum logic [2:0] {MB_RD, MB_ALPHA, MB_INV, MB_TAU, MB_X} mul_b_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD} acc_op_t;
	typedef enum logic {DIV_TAU, DIV_INV} div_sel_t;
	typedef enum logic [1:0] {SRC_ZERO, SRC_MEM, SRC_TAU} res_src_t;

	typedef struct packed {
		logic             mem_rd;
		logic             mem_wr;
		logic [ADDR_W-1:0] mem_addr;
		wd_sel_t          wd_sel;
		mul_a_t           mul_a;
		mul_b_t           mul_b;
		acc_op_t          acc_op;
		logic             ld_x;
		logic             ld_alpha;
		logic             ld_sum;
		logic             ld_w;
		logic             ld_beta;
		logic             ld_tau;
		logic             ld_inv;
		logic             sqrt_go;
		logic             div_go;
		div_sel_t         div_sel;
		logic             tau_wr;
		logic             tau_zero;
		logic [COL_W-1:0] tau_idx;
		logic             tau_rd;
		res_src_t         res_src;
	} cmd_t;

	typedef struct packed {
		logic norm_zero;
		logic unit_busy;
	} sts_t;

	typedef struct packed {
		logic valid;
		logic status;
	} res_t;

	// Signs a magnitude and clamps it to the word range.
	function automatic logic [WORD_W-1:0] from_mag(input logic [MAG_W-1:0] m, input logic neg);
		logic [WORD_W-1:0] r;
		if (m > MAG_W'(WMAX)) begin
			r = neg ? WMIN : WMAX;
		end else begin
			r = neg ? (~m[WORD_W-1:0] + WORD_W'(1)) : m[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/hqr_div.sv */
// Bit-serial fixed-point divider: (num * 2^16) / den, truncated and saturated.
module hqr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [hqr_pkg::WORD_W-1:0] num,
	input  logic [hqr_pkg::WORD_W-1:0] den,
	output logic                      busy,
	output logic [hqr_pkg::WORD_W-1:0] result
);
	import hqr_pkg::*;

	localparam int STEPS = MAG_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  dvd_q;
	logic [MAG_W-1:0]  quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dsr_q;
	logic              neg_q;
	logic              zero_q;
	logic [WORD_W:0]   rem_sh;
	logic              fits;
	logic [WORD_W-1:0] num_mag;
	logic [WORD_W-1:0] den_mag;

	assign num_mag = num[WORD_W-1] ? (~num + WORD_W'(1)) : num;
	assign den_mag = den[WORD_W-1] ? (~den + WORD_W'(1)) : den;
	assign rem_sh  = {rem_q, dvd_q[MAG_W-1]};
	assign fits    = rem_sh >= {1'b0, dsr_q};
	assign busy    = cnt_q != '0;
	assign result  = zero_q ? '0 : from_mag(quo_q, neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= {num_mag, {FRAC{1'b0}}};
			dsr_q  <= den_mag;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[WORD_W-1] ^ den[WORD_W-1];
			zero_q <= den == '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? WORD_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[WORD_W-1:0];
		end
	end

endmodule

/* hw/rtl/hqr_sqrt.sv */
// Digit-by-digit square root: floor(sqrt(x * 2^16)), zero for x <= 0.
module hqr_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [hqr_pkg::WORD_W-1:0] x,
	output logic                      busy,
	output logic [hqr_pkg::WORD_W-1:0] result
);
	import hqr_pkg::*;

	localparam int STEPS = MAG_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int REM_W = STEPS + 2;

	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rad_q;
	logic [STEPS-1:0] root_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   trial;
	logic             fits;

	assign rem_sh = {rem_q[REM_W-2:0], rad_q[MAG_W-1 -: 2]};
	assign trial  = (REM_W + 1)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;
	assign busy   = cnt_q != '0;
	assign result = WORD_W'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= x[WORD_W-1] ? '0 : {x, {FRAC{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q  <= {rad_q[MAG_W-3:0], 2'b00};
			root_q <= {root_q[STEPS-2:0], fits};
			rem_q  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
		end
	end

endmodule

/* hw/rtl/hqr_datapath.sv */
// Datapath: matrix memory, tau registers, multiplier pipe, accumulator and serial units.
module hqr_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hqr_pkg::cmd_t             cmd,
	input  logic [hqr_pkg::WORD_W-1:0] value,
	output hqr_pkg::sts_t             sts,
	output logic [hqr_pkg::WORD_W-1:0] res_data
);
	import hqr_pkg::*;

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		return (s[WORD_W] != s[WORD_W-1]) ? (s[WORD_W] ? WMIN : WMAX) : s[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		return (s[WORD_W] != s[WORD_W-1]) ? (s[WORD_W] ? WMIN : WMAX) : s[WORD_W-1:0];
	endfunction

	logic [WORD_W-1:0] mem [MAX_ROWS*MAX_COLS];
	logic [WORD_W-1:0] taus_q [MAX_COLS];

	logic [WORD_W-1:0] rdata_q, tau_rd_q, x_q, alpha_q, beta_q, tau_q, inv_q, w_q, sum_q, acc_q;
	logic signed [2*WORD_W-1:0] prod_s1;
	logic [WORD_W-1:0] prod_s2;

	logic [WORD_W-1:0]   mul_a, mul_b, wdata, div_num, div_den;
	logic [2*WORD_W-1:0] pmag, prnd;
	logic                pneg;
	logic                div_busy, sq_busy;
	logic [WORD_W-1:0]   div_res, sq_res;

	always_comb begin
		case (cmd.mul_a)
			MA_ALPHA: mul_a = alpha_q;
			MA_X:     mul_a = x_q;
			MA_SUM:   mul_a = sum_q;
			MA_W:     mul_a = w_q;
			default:  mul_a = rdata_q;
		endcase
		case (cmd.mul_b)
			MB_ALPHA: mul_b = alpha_q;
			MB_INV:   mul_b = inv_q;
			MB_TAU:   mul_b = tau_q;
			MB_X:     mul_b = x_q;
			default:  mul_b = rdata_q;
		endcase
		case (cmd.wd_sel)
			WD_PROD: wdata = prod_s2;
			WD_BETA: wdata = beta_q;
			WD_SUB:  wdata = sat_sub(rdata_q, prod_s2);
			default: wdata = value;
		endcase
		case (cmd.res_src)
			SRC_MEM: res_data = rdata_q;
			SRC_TAU: res_data = tau_rd_q;
			default: res_data = '0;
		endcase
	end

	// Product rounding works on the magnitude so that ties round away from zero.
	assign pneg = prod_s1[2*WORD_W-1];
	assign pmag = pneg ? (~prod_s1 + (2*WORD_W)'(1)) : prod_s1;
	assign prnd = pmag + ((2*WORD_W)'(1) << (FRAC - 1));

	assign div_num = (cmd.div_sel == DIV_TAU) ? sat_sub(beta_q, alpha_q)
		: (WORD_W'(1) << FRAC);
	assign div_den = (cmd.div_sel == DIV_TAU) ? beta_q : sat_sub(alpha_q, beta_q);

	hqr_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .num(div_num), .den(div_den),
		.busy(div_busy), .result(div_res)
	);

	hqr_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(cmd.sqrt_go), .x(acc_q),
		.busy(sq_busy), .result(sq_res)
	);

	assign sts.norm_zero = acc_q == '0;
	assign sts.unit_busy = div_busy | sq_busy;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[cmd.mem_addr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[cmd.mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLS; i++) begin
				taus_q[i] <= '0;
			end
		end else if (cmd.tau_wr) begin
			taus_q[cmd.tau_idx] <= cmd.tau_zero ? '0 : tau_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(mul_a) * $signed(mul_b);
		prod_s2 <= from_mag(prnd[2*WORD_W-1:FRAC], pneg);
		if (cmd.tau_rd) tau_rd_q <= taus_q[cmd.tau_idx];
		if (cmd.ld_x) x_q <= rdata_q;
		if (cmd.ld_alpha) alpha_q <= rdata_q;
		if (cmd.ld_sum) sum_q <= sat_add(rdata_q, acc_q);
		if (cmd.ld_w) w_q <= prod_s2;
		if (cmd.ld_beta) beta_q <= alpha_q[WORD_W-1] ? sq_res : (~sq_res + WORD_W'(1));
		if (cmd.ld_tau) tau_q <= div_res;
		if (cmd.ld_inv) inv_q <= div_res;
		case (cmd.acc_op)
			ACC_CLR: acc_q <= '0;
			ACC_ADD: acc_q <= sat_add(acc_q, prod_s2);
			default: acc_q <= acc_q;
		endcase
	end

endmodule

/* hw/rtl/hqr_ctrl.sv */
// Controller: host command decode, result stage and the factorization sequencer.
module hqr_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic [hqr_pkg::ROW_W-1:0] row,
	input  logic [hqr_pkg::COL_W-1:0] col,
	input  logic [hqr_pkg::DIM_W-1:0] row_count,
	input  logic [hqr_pkg::DIM_W-1:0] col_count,
	input  logic                     advance,
	input  hqr_pkg::sts_t            sts,
	output hqr_pkg::cmd_t            cmd,
	output hqr_pkg::res_t            res
);
	import hqr_pkg::*;

	localparam int NS = 43;

	typedef enum logic [NS-1:0] {
		S_IDLE  = NS'(1) << 0,  S_COL   = NS'(1) << 1,  S_N_RD  = NS'(1) << 2,
		S_N_MUL = NS'(1) << 3,  S_N_P   = NS'(1) << 4,  S_N_ACC = NS'(1) << 5,
		S_A_RD  = NS'(1) << 6,  S_TAU0  = NS'(1) << 7,  S_A_LD  = NS'(1) << 8,
		S_A_MUL = NS'(1) << 9,  S_A_P   = NS'(1) << 10, S_A_ACC = NS'(1) << 11,
		S_SQ_GO = NS'(1) << 12, S_SQ_W  = NS'(1) << 13, S_TD_GO = NS'(1) << 14,
		S_TD_W  = NS'(1) << 15, S_ID_GO = NS'(1) << 16, S_ID_W  = NS'(1) << 17,
		S_S_RD  = NS'(1) << 18, S_S_MUL = NS'(1) << 19, S_S_P   = NS'(1) << 20,
		S_S_WR  = NS'(1) << 21, S_B_WR  = NS'(1) << 22, S_D_CLR = NS'(1) << 23,
		S_D_RV  = NS'(1) << 24, S_D_LV  = NS'(1) << 25, S_D_RY  = NS'(1) << 26,
		S_D_MUL = NS'(1) << 27, S_D_P   = NS'(1) << 28, S_D_ACC = NS'(1) << 29,
		S_C_RD  = NS'(1) << 30, S_C_SUM = NS'(1) << 31, S_C_MUL = NS'(1) << 32,
		S_C_P   = NS'(1) << 33, S_C_WR  = NS'(1) << 34, S_U_RV  = NS'(1) << 35,
		S_U_LV  = NS'(1) << 36, S_U_RY  = NS'(1) << 37, S_U_MUL = NS'(1) << 38,
		S_U_P   = NS'(1) << 39, S_U_WR  = NS'(1) << 40, S_K_NX  = NS'(1) << 41,
		S_NXCOL = NS'(1) << 42
	} state_t;

	state_t             state_q, state_d;
	logic [ROW_W-1:0]   r_q, r_d;
	logic [COL_W-1:0]   j_q, j_d, k_q, k_d;
	logic [DIM_W-1:0]   m_q, m_d, n_q, n_d;
	logic               s1_valid_q, s1_status_q, s1_status_d;
	res_src_t           s1_src_q, s1_src_d;
	logic               accept, elem_ok, shape_ok, last_r;
	logic [DIM_W-1:0]   j1;

	assign in_ready = (state_q == S_IDLE) && (!s1_valid_q || advance);
	assign accept   = in_valid && in_ready;
	assign elem_ok  = (DIM_W'(row) < row_count) && (DIM_W'(col) < col_count);
	assign shape_ok = (row_count != '0) && (col_count != '0)
		&& (row_count <= DIM_W'(MAX_ROWS)) && (col_count <= DIM_W'(MAX_COLS))
		&& (col_count <= row_count);
	assign j1       = DIM_W'(j_q) + DIM_W'(1);
	assign last_r   = DIM_W'(r_q) == (m_q - DIM_W'(1));
	assign res.valid  = s1_valid_q;
	assign res.status = s1_status_q;

	always_comb begin
		cmd         = '0;
		cmd.res_src = s1_src_q;
		cmd.tau_idx = j_q;
		cmd.mem_addr = {r_q, j_q};
		state_d     = state_q;
		r_d = r_q; j_d = j_q; k_d = k_q; m_d = m_q; n_d = n_q;
		s1_status_d = 1'b0;
		s1_src_d    = SRC_ZERO;

		case (kind_t'(kind))
			KIND_WRITE, KIND_READ: begin
				s1_status_d = !elem_ok;
				s1_src_d    = (elem_ok && kind_t'(kind) == KIND_READ) ? SRC_MEM : SRC_ZERO;
			end
			KIND_TAU: begin
				s1_status_d = !(DIM_W'(col) < col_count);
				s1_src_d    = s1_status_d ? SRC_ZERO : SRC_TAU;
			end
			default: s1_status_d = !shape_ok;
		endcase

		case (state_q)
			S_IDLE: begin
				cmd.mem_addr = {row, col};
				cmd.tau_idx  = col;
				cmd.wd_sel   = WD_VALUE;
				if (accept) begin
					case (kind_t'(kind))
						KIND_WRITE: cmd.mem_wr = elem_ok;
						KIND_READ:  cmd.mem_rd = elem_ok;
						KIND_TAU:   cmd.tau_rd = 1'b1;
						default: begin
							if (shape_ok) begin
								j_d = '0; m_d = row_count; n_d = col_count;
								state_d = S_COL;
							end
						end
					endcase
				end
			end
			S_COL: begin
				cmd.acc_op = ACC_CLR;
				r_d = j1[ROW_W-1:0];
				state_d = (j1 < m_q) ? S_N_RD : S_TAU0;
			end
			S_N_RD: begin cmd.mem_rd = 1'b1; state_d = S_N_MUL; end
			S_N_MUL: begin cmd.mul_a = MA_RD; cmd.mul_b = MB_RD; state_d = S_N_P; end
			S_N_P: state_d = S_N_ACC;
			S_N_ACC: begin
				cmd.acc_op = ACC_ADD;
				if (last_r) state_d = S_A_RD;
				else begin r_d = r_q + ROW_W'(1); state_d = S_N_RD; end
			end
			S_A_RD: begin
				cmd.mem_addr = {j_q, j_q};
				if (sts.norm_zero) state_d = S_TAU0;
				else begin cmd.mem_rd = 1'b1; state_d = S_A_LD; end
			end
			S_TAU0: begin cmd.tau_wr = 1'b1; cmd.tau_zero = 1'b1; state_d = S_NXCOL; end
			S_A_LD: begin cmd.ld_alpha = 1'b1; state_d = S_A_MUL; end
			S_A_MUL: begin cmd.mul_a = MA_ALPHA; cmd.mul_b = MB_ALPHA; state_d = S_A_P; end
			S_A_P: state_d = S_A_ACC;
			S_A_ACC: begin cmd.acc_op = ACC_ADD; state_d = S_SQ_GO; end
			S_SQ_GO: begin cmd.sqrt_go = 1'b1; state_d = S_SQ_W; end
			S_SQ_W: if (!sts.unit_busy) begin cmd.ld_beta = 1'b1; state_d = S_TD_GO; end
			S_TD_GO: begin cmd.div_go = 1'b1; cmd.div_sel = DIV_TAU; state_d = S_TD_W; end
			S_TD_W: if (!sts.unit_busy) begin cmd.ld_tau = 1'b1; state_d = S_ID_GO; end
			S_ID_GO: begin cmd.div_go = 1'b1; cmd.div_sel = DIV_INV; state_d = S_ID_W; end
			S_ID_W: begin
				if (!sts.unit_busy) begin
					cmd.ld_inv = 1'b1; r_d = j1[ROW_W-1:0]; state_d = S_S_RD;
				end
			end
			S_S_RD: begin cmd.mem_rd = 1'b1; state_d = S_S_MUL; end
			S_S_MUL: begin cmd.mul_a = MA_RD; cmd.mul_b = MB_INV; state_d = S_S_P; end
			S_S_P: state_d = S_S_WR;
			S_S_WR: begin
				cmd.mem_wr = 1'b1; cmd.wd_sel = WD_PROD;
				if (last_r) state_d = S_B_WR;
				else begin r_d = r_q + ROW_W'(1); state_d = S_S_RD; end
			end
			S_B_WR: begin
				cmd.mem_addr = {j_q, j_q}; cmd.mem_wr = 1'b1; cmd.wd_sel = WD_BETA;
				cmd.tau_wr = 1'b1;
				k_d = j1[COL_W-1:0];
				state_d = (j1 < n_q) ? S_D_CLR : S_NXCOL;
			end
			S_D_CLR: begin cmd.acc_op = ACC_CLR; r_d = j1[ROW_W-1:0]; state_d = S_D_RV; end
			S_D_RV: begin cmd.mem_rd = 1'b1; state_d = S_D_LV; end
			S_D_LV: begin cmd.ld_x = 1'b1; state_d = S_D_RY; end
			S_D_RY: begin cmd.mem_addr = {r_q, k_q}; cmd.mem_rd = 1'b1; state_d = S_D_MUL; end
			S_D_MUL: begin cmd.mul_a = MA_X; cmd.mul_b = MB_RD; state_d = S_D_P; end
			S_D_P: state_d = S_D_ACC;
			S_D_ACC: begin
				cmd.acc_op = ACC_ADD;
				if (last_r) state_d = S_C_RD;
				else begin r_d = r_q + ROW_W'(1); state_d = S_D_RV; end
			end
			S_C_RD: begin cmd.mem_addr = {j_q, k_q}; cmd.mem_rd = 1'b1; state_d = S_C_SUM; end
			S_C_SUM: begin cmd.ld_sum = 1'b1; state_d = S_C_MUL; end
			S_C_MUL: begin cmd.mul_a = MA_SUM; cmd.mul_b = MB_TAU; state_d = S_C_P; end
			S_C_P: state_d = S_C_WR;
			S_C_WR: begin
				cmd.mem_addr = {j_q, k_q}; cmd.mem_wr = 1'b1; cmd.wd_sel = WD_SUB;
				cmd.ld_w = 1'b1; r_d = j1[ROW_W-1:0]; state_d = S_U_RV;
			end
			S_U_RV: begin cmd.mem_rd = 1'b1; state_d = S_U_LV; end
			S_U_LV: begin cmd.ld_x = 1'b1; state_d = S_U_RY; end
			S_U_RY: begin cmd.mem_addr = {r_q, k_q}; cmd.mem_rd = 1'b1; state_d = S_U_MUL; end
			S_U_MUL: begin cmd.mul_a = MA_W; cmd.mul_b = MB_X; state_d = S_U_P; end
			S_U_P: state_d = S_U_WR;
			S_U_WR: begin
				cmd.mem_addr = {r_q, k_q}; cmd.mem_wr = 1'b1; cmd.wd_sel = WD_SUB;
				if (last_r) state_d = S_K_NX;
				else begin r_d = r_q + ROW_W'(1); state_d = S_U_RV; end
			end
			S_K_NX: begin
				if (DIM_W'(k_q) == n_q - DIM_W'(1)) state_d = S_NXCOL;
				else begin k_d = k_q + COL_W'(1); state_d = S_D_CLR; end
			end
			S_NXCOL: begin
				if (DIM_W'(j_q) == n_q - DIM_W'(1)) state_d = S_IDLE;
				else begin j_d = j_q + COL_W'(1); state_d = S_COL; end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			s1_valid_q  <= 1'b0;
			s1_status_q <= 1'b0;
			s1_src_q    <= SRC_ZERO;
			r_q <= '0; j_q <= '0; k_q <= '0; m_q <= '0; n_q <= '0;
		end else begin
			state_q <= state_d;
			r_q <= r_d; j_q <= j_d; k_q <= k_d; m_q <= m_d; n_q <= n_d;
			if (accept) begin
				s1_valid_q  <= 1'b1;
				s1_status_q <= s1_status_d;
				s1_src_q    <= s1_src_d;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/householder_qr_factor.sv */
// Top level of the Householder QR factor block: configuration, result register, checks.
// A host writes the elements of a row_count x col_count Q16.16 matrix one beat at a time
// (kind 0), reads elements back (kind 2) or reads the reflector scales tau (kind 3). Every
// input beat yields exactly one result beat on data/status; a rejected index gives status 1
// and data zero. Element writes, element reads and tau reads are accepted one per cycle
// while the controller is idle and the result stage can move on. Their result passes
// through a result stage and an output register, so the input side can take one more beat
// while a result waits to be taken. A factor command (kind 1) runs unblocked Householder QR
// in place and holds in_ready low until it finishes; its own result beat is issued right
// away. The factorization is driven by a sequencer over a single-port matrix memory, one
// multiplier pipe, a 24-step square root and a 48-step divider. For each column j it forms
// the norm of the entries below the diagonal, computes the square root and two divisions,
// scales the column, and then updates each later column. Its speed is set by the one
// memory port (one element read or written per cycle) and by the bit-serial units.
// row_count and col_count are sampled when a factor starts. Elements never written read as
// unknown, and factoring over them gives unknown results.
module householder_qr_factor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [hqr_pkg::DIM_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       kind,
	input  logic [hqr_pkg::ROW_W-1:0]        row,
	input  logic [hqr_pkg::COL_W-1:0]        col,
	input  logic signed [hqr_pkg::WORD_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [hqr_pkg::WORD_W-1:0] data,
	output logic                             status
);
	import hqr_pkg::*;

	localparam logic [0:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [0:0] CFG_COL_COUNT = 1'b1;

	logic [DIM_W-1:0]  row_count_q, col_count_q;
	logic              out_valid_q, status_q;
	logic [WORD_W-1:0] data_q;
	logic              advance;
	cmd_t              cmd;
	sts_t              sts;
	res_t              res;
	logic [WORD_W-1:0] res_data;

	// The result stage moves into the output register whenever that register is free or
	// its beat is being taken in the same cycle.
	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign data      = $signed(data_q);
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_W'(MAX_ROWS);
			col_count_q <= DIM_W'(MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
			status_q    <= res.status;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= res_data;
		end
	end

	hqr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .row(row), .col(col), .row_count(row_count_q), .col_count(col_count_q),
		.advance(advance), .sts(sts), .cmd(cmd), .res(res)
	);

	hqr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .value(value), .sts(sts), .res_data(res_data)
	);

	// A rejected beat never carries data.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> data == '0)
		else $error("rejected result carries nonzero data");

	// Every accepted beat is held in the result stage on the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> res.valid)
		else $error("accepted beat produced no result");

	// A well-shaped factor keeps the input closed on the following cycle.
	a_factor_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_FACTOR && row_count_q != '0
		&& col_count_q != '0 && row_count_q <= DIM_W'(MAX_ROWS)
		&& col_count_q <= row_count_q |=> !in_ready)
		else $error("factor did not hold the input");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for householder_qr_factor: directed and random element traffic with factors.
module testbench;
	import hqr_pkg::*;

	localparam logic [0:0] REG_ROWS = 1'b0;
	localparam logic [0:0] REG_COLS = 1'b1;
	localparam longint WTOP = 64'sd2147483647;
	localparam longint WBOT = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] kind;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic signed [WORD_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic signed [WORD_W-1:0] data;
	logic status;

	int fail_count = 0;
	bit send_burst = 1'b0;
	bit take_burst = 1'b0;

	// Mirror of the block: matrix, reflector scales and shape registers, plus the
	// queue of result beats still owed by the block, oldest first.
	class qr_scoreboard;
		longint cells[MAX_ROWS][MAX_COLS];
		bit written[MAX_ROWS][MAX_COLS];
		longint taus[MAX_COLS];
		int unsigned rows_used = 16;
		int unsigned cols_used = 16;
		logic [WORD_W-1:0] owed_data[$];
		logic owed_status[$];

		function longint clamp(longint v);
			if (v > WTOP) return WTOP;
			if (v < WBOT) return WBOT;
			return v;
		endfunction

		function longint signed_mag(longint unsigned m, bit neg);
			if (m > longint'(WTOP)) return neg ? WBOT : WTOP;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function longint fxmul(longint a, longint b);
			longint unsigned ma, mb, p;
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			p = ma * mb;
			return signed_mag((p + 64'd32768) >> FRAC, (a < 0) != (b < 0));
		endfunction

		function longint fxdiv(longint a, longint b);
			longint unsigned ma, mb;
			if (b == 0) return 0;
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			return signed_mag((ma << FRAC) / mb, (a < 0) != (b < 0));
		endfunction

		// Floor of the square root of x scaled by 2^16; the root fits in 24 bits.
		function longint fxsqrt(longint x);
			longint unsigned t, r, c;
			if (x <= 0) return 0;
			t = longint'(x) << FRAC;
			r = 0;
			for (int i = 23; i >= 0; i--) begin
				c = r | (64'd1 << i);
				if (c * c <= t) r = c;
			end
			return longint'(r);
		endfunction

		function bit shape_ok();
			return rows_used != 0 && cols_used != 0 && rows_used <= MAX_ROWS &&
				cols_used <= MAX_COLS && cols_used <= rows_used;
		endfunction

		// A factor is safe to issue when it is rejected outright or every element it touches is set.
		function bit region_ready();
			if (!shape_ok()) return 1'b1;
			for (int r = 0; r < rows_used; r++)
				for (int c = 0; c < cols_used; c++)
					if (!written[r][c]) return 1'b0;
			return 1'b1;
		endfunction

		function void householder(int m, int n);
			longint alpha, norm, s, beta, tau, inv, dot, w;
			for (int j = 0; j < n; j++) begin
				alpha = cells[j][j];
				norm = 0;
				for (int r = j + 1; r < m; r++)
					norm = clamp(norm + fxmul(cells[r][j], cells[r][j]));
				if (norm == 0) begin
					taus[j] = 0;
					continue;
				end
				s = fxsqrt(clamp(fxmul(alpha, alpha) + norm));
				// Zero alpha counts as positive.
				beta = alpha >= 0 ? -s : s;
				tau = fxdiv(clamp(beta - alpha), beta);
				inv = fxdiv(64'sd65536, clamp(alpha - beta));
				for (int r = j + 1; r < m; r++)
					cells[r][j] = fxmul(cells[r][j], inv);
				cells[j][j] = beta;
				taus[j] = tau;
				for (int jj = j + 1; jj < n; jj++) begin
					dot = 0;
					for (int r = j + 1; r < m; r++)
						dot = clamp(dot + fxmul(cells[r][j], cells[r][jj]));
					w = fxmul(clamp(cells[j][jj] + dot), tau);
					cells[j][jj] = clamp(cells[j][jj] - w);
					for (int r = j + 1; r < m; r++)
						cells[r][jj] = clamp(cells[r][jj] - fxmul(w, cells[r][j]));
				end
			end
		endfunction

		function void note_input(logic [1:0] k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
				logic [WORD_W-1:0] v);
			bit elem_ok;
			longint d;
			logic st;
			elem_ok = r < rows_used && c < cols_used;
			d = 0;
			st = 1'b0;
			case (kind_t'(k))
				KIND_WRITE: begin
					if (elem_ok) begin
						cells[r][c] = longint'($signed(v));
						written[r][c] = 1'b1;
					end else st = 1'b1;
				end
				KIND_FACTOR: begin
					if (shape_ok()) householder(rows_used, cols_used);
					else st = 1'b1;
				end
				KIND_READ: begin
					if (elem_ok) d = cells[r][c];
					else st = 1'b1;
				end
				default: begin
					if (c < cols_used) d = taus[c];
					else st = 1'b1;
				end
			endcase
			owed_data.push_back(d[WORD_W-1:0]);
			owed_status.push_back(st);
		endfunction

		function string check_result(logic [WORD_W-1:0] d, logic st);
			logic [WORD_W-1:0] want_d;
			logic want_st;
			string msg;
			if (owed_data.size() == 0) return "result beat with nothing outstanding";
			want_d = owed_data.pop_front();
			want_st = owed_status.pop_front();
			msg = "";
			if (d !== want_d)
				msg = $sformatf("data %h, expected %h", d, want_d);
			if (st !== want_st)
				msg = {msg, $sformatf(" status %b, expected %b", st, want_st)};
			return msg;
		endfunction

		function int outstanding();
			return owed_data.size();
		endfunction
	endclass

	qr_scoreboard sb;

	householder_qr_factor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data(data),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Presents one beat after a random gap and holds it until the block takes it.
	// Valid stays high after the handshake so that a back-to-back beat needs no dip.
	task automatic send_beat(kind_t k, int r, int c, logic [WORD_W-1:0] v);
		int gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		row <= r[ROW_W-1:0];
		col <= c[COL_W-1:0];
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_input(k, r[ROW_W-1:0], c[COL_W-1:0], v);
	endtask

	// Registers only change once every beat is back and any factor has finished.
	task automatic set_register(logic [0:0] idx, int unsigned val);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0 || !in_ready) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS) sb.rows_used = val & 31;
		else sb.cols_used = val & 31;
	endtask

	task automatic configure(int unsigned rows, int unsigned cols);
		set_register(REG_ROWS, rows);
		set_register(REG_COLS, cols);
	endtask

	// Mostly moderate values so the factor stays out of saturation; some full-range and extremes.
	function automatic logic [WORD_W-1:0] pick_value();
		int sel;
		logic [WORD_W-1:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 70) m = $urandom_range(0, 1 << 19);
		else if (sel < 85) m = $urandom_range(0, 1 << 16);
		else if (sel < 95) return $urandom;
		else begin
			case ($urandom_range(0, 2))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				default: return 32'h0;
			endcase
		end
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic int span(int unsigned n);
		return n > MAX_ROWS ? MAX_ROWS : n;
	endfunction

	task automatic fill_matrix();
		for (int r = 0; r < span(sb.rows_used); r++)
			for (int c = 0; c < span(sb.cols_used); c++)
				send_beat(KIND_WRITE, r, c, pick_value());
	endtask

	// Mixed traffic on the current shape. Reads of never-written elements turn into tau reads.
	task automatic random_traffic(int count);
		int pick, r, c, factors, factor_cap, lim_r, lim_c;
		factors = 0;
		lim_r = span(sb.rows_used);
		lim_c = span(sb.cols_used);
		factor_cap = lim_r * lim_c > 64 ? 2 : 4;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, 15);
			c = $urandom_range(0, 15);
			if (pick < 65 && $urandom_range(0, 9) != 0 && lim_r > 0 && lim_c > 0) begin
				r = $urandom_range(0, lim_r - 1);
				c = $urandom_range(0, lim_c - 1);
			end
			if (pick < 30) begin
				send_beat(KIND_WRITE, r, c, pick_value());
			end else if (pick < 65 || pick >= 93) begin
				if (r < sb.rows_used && c < sb.cols_used && !sb.written[r][c])
					send_beat(KIND_TAU, r, c, $urandom);
				else
					send_beat(KIND_READ, r, c, $urandom);
			end else if (pick < 85) begin
				send_beat(KIND_TAU, r, c, $urandom);
			end else if (sb.region_ready() && factors < factor_cap) begin
				send_beat(KIND_FACTOR, r, c, $urandom);
				factors++;
			end else begin
				send_beat(KIND_TAU, r, c, $urandom);
			end
		end
	endtask

	// Result side: random stalls, with stretches where it always takes.
	initial begin
		int stall;
		string msg;
		out_ready <= 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			msg = sb.check_result(data, status);
			if (msg != "") report(msg);
		end
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned phase_rows[17] = '{2, 16, 1, 5, 0, 4, 8, 17, 16, 3, 6, 31, 12, 2, 7, 10, 4};
		int unsigned phase_cols[17] = '{1, 16, 1, 4, 3, 4, 3, 2, 1, 3, 6, 31, 10, 2, 5, 12, 1};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_WRITE;
		row <= '0;
		col <= '0;
		value <= '0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero alpha on the first column, extreme values, rejected indexes,
		// a full factor and read-back, then a shape with more columns than rows.
		configure(3, 2);
		send_beat(KIND_WRITE, 0, 0, 32'h0000_0000);
		send_beat(KIND_WRITE, 1, 0, 32'h0001_0000);
		send_beat(KIND_WRITE, 2, 0, 32'hFFFE_0000);
		send_beat(KIND_WRITE, 0, 1, 32'h7FFF_FFFF);
		send_beat(KIND_WRITE, 1, 1, 32'h8000_0000);
		send_beat(KIND_WRITE, 2, 1, 32'hFFFF_FFFF);
		send_beat(KIND_WRITE, 3, 0, 32'h1234_5678);
		send_beat(KIND_WRITE, 0, 2, 32'h1234_5678);
		send_beat(KIND_READ, 3, 0, 32'h0);
		send_beat(KIND_TAU, 0, 2, 32'h0);
		send_beat(KIND_READ, 2, 1, 32'h0);
		send_beat(KIND_FACTOR, 0, 0, 32'h0);
		send_beat(KIND_TAU, 0, 0, 32'h0);
		send_beat(KIND_TAU, 0, 1, 32'h0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 2; c++)
				send_beat(KIND_READ, r, c, 32'h0);
		configure(2, 3);
		send_beat(KIND_FACTOR, 15, 15, 32'hFFFF_FFFF);
		send_beat(KIND_TAU, 0, 2, 32'h0);
		send_beat(KIND_READ, 15, 15, 32'h0);
		send_beat(KIND_WRITE, 15, 15, 32'hFFFF_FFFF);

		for (int p = 0; p < 17; p++) begin
			configure(phase_rows[p], phase_cols[p]);
			if (sb.shape_ok()) fill_matrix();
			random_traffic(50);
		end

		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
